[src/owhh_pkg.sv]
// Shared types and constants for the omni wheel heading hold block.
package owhh_pkg;

    localparam int CordicSteps = 16;
    localparam int StepW       = 5;

    localparam logic signed [19:0] KLin  = 20'sd390075;
    localparam logic signed [17:0] KYaw  = 18'sd68956;
    localparam logic signed [22:0] KCorr = 23'sd3309899;

    localparam logic signed [31:0] OneQ28    = 32'sd268435456;
    localparam logic signed [15:0] HeadLimit = 16'sd23040;

    localparam logic [1:0] RegGainProp = 2'd0;
    localparam logic [1:0] RegGainDiff = 2'd1;
    localparam logic [1:0] RegGainSum  = 2'd2;

    // Angle table, degrees in Q.16, one entry per vectoring step.
    function automatic logic signed [23:0] atan_deg(input logic [StepW-1:0] i);
        logic signed [23:0] r;
        begin
            case (i)
                5'd0:  r = 24'sd2949120;
                5'd1:  r = 24'sd1740967;
                5'd2:  r = 24'sd919879;
                5'd3:  r = 24'sd466945;
                5'd4:  r = 24'sd234379;
                5'd5:  r = 24'sd117304;
                5'd6:  r = 24'sd58666;
                5'd7:  r = 24'sd29335;
                5'd8:  r = 24'sd14668;
                5'd9:  r = 24'sd7334;
                5'd10: r = 24'sd3667;
                5'd11: r = 24'sd1833;
                5'd12: r = 24'sd917;
                5'd13: r = 24'sd458;
                5'd14: r = 24'sd229;
                5'd15: r = 24'sd115;
                5'd16: r = 24'sd57;
                5'd17: r = 24'sd29;
                5'd18: r = 24'sd14;
                5'd19: r = 24'sd7;
                5'd20: r = 24'sd4;
                5'd21: r = 24'sd2;
                5'd22: r = 24'sd1;
                default: r = 24'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

[src/owhh_cordic.sv]
// Iterative CORDIC vectoring unit: atan2 in degrees Q9.7, one step per cycle.
module owhh_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [33:0] vec_s,
    input  logic signed [33:0] vec_c,
    output logic               done,
    output logic signed [15:0] heading
);
    import owhh_pkg::*;

    logic signed [35:0] x_reg, y_reg;
    logic signed [35:0] x_next, y_next;
    logic signed [24:0] z_reg, z_next;
    logic [StepW-1:0]   step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               zero_reg, zero_next;
    logic               done_reg, done_next;
    logic signed [35:0] dx, dy;
    logic signed [24:0] zr;
    logic signed [15:0] zq;

    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign zr = (z_reg + 25'sd256) >>> 9;
    assign zq = (zr > 25'(HeadLimit)) ? HeadLimit :
                (zr < -25'(HeadLimit)) ? -HeadLimit : zr[15:0];

    // Pre-rotate on start, then one vectoring step per cycle.
    always_comb begin
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        step_next = step_reg; busy_next = busy_reg;
        zero_next = zero_reg; done_next = 1'b0;
        if (start) begin
            zero_next = (vec_s == 34'sd0) && (vec_c == 34'sd0);
            step_next = '0;
            busy_next = 1'b1;
            if (vec_c < 0) begin
                if (vec_s >= 0) begin
                    x_next = 36'(vec_s); y_next = -36'(vec_c); z_next = 25'sd5898240;
                end else begin
                    x_next = -36'(vec_s); y_next = 36'(vec_c); z_next = -25'sd5898240;
                end
            end else begin
                x_next = 36'(vec_c); y_next = 36'(vec_s); z_next = '0;
            end
        end else if (busy_reg) begin
            if (y_reg >= 0) begin
                x_next = x_reg + dx; y_next = y_reg - dy;
                z_next = z_reg + 25'(atan_deg(step_reg));
            end else begin
                x_next = x_reg - dx; y_next = y_reg + dy;
                z_next = z_reg - 25'(atan_deg(step_reg));
            end
            step_next = step_reg + 1'b1;
            if (step_reg == StepW'(CordicSteps - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next; zero_reg <= zero_next;
    end

    assign done    = done_reg;
    assign heading = zero_reg ? 16'sd0 : zq;

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start) else $error("cordic restarted while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without run");
    a_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("still busy at done");
endmodule

[src/omni_wheel_heading_hold.sv]
// Top level: omni wheel kinematics, heading hold and sequencer.
// Path from input accept to result valid: 8 multiply steps, 16 CORDIC steps
//   and done in the vectoring unit, 3 gain steps, correction, output load;
//   longer while an older word waits.
// One item at a time: a new word is accepted only when the sequencer is idle.
// Reset (aresetn, synchronous, active low): gains to defaults, correction,
//   last error and setpoint to zero, output channel empty.
module omni_wheel_heading_hold (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_cmd_vx,
    input  logic signed [15:0] s_cmd_vy,
    input  logic signed [15:0] s_cmd_wz,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_wheel_front_right,
    output logic signed [23:0] m_wheel_front_left,
    output logic signed [23:0] m_wheel_rear_left,
    output logic signed [23:0] m_wheel_rear_right,
    output logic signed [15:0] m_heading_deg
);
    import owhh_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_HEAD = 6'b000100,
        ST_PID  = 6'b001000,
        ST_CORR = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] mstep_reg, mstep_next;

    logic [15:0] gain_prop_reg, gain_diff_reg, gain_sum_reg;
    logic signed [15:0] corr_reg, setpoint_reg;
    logic signed [16:0] last_err_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg, vx_reg, vy_reg, wz_reg;

    logic signed [33:0] s_acc_reg, c_acc_reg;
    logic signed [47:0] base_reg;
    logic signed [47:0] lsum_reg, ldif_reg;
    logic signed [47:0] acc_reg;
    logic signed [16:0] err_reg;

    logic signed [23:0] wfr_reg, wfl_reg, wrl_reg, wrr_reg;
    logic signed [15:0] head_out_reg;
    logic signed [23:0] out_fr_reg, out_fl_reg, out_rl_reg, out_rr_reg;
    logic signed [15:0] out_head_reg;
    logic               m_valid_reg;
    logic               out_load;

    logic               cordic_start, cordic_done;
    logic signed [15:0] cordic_head;
    logic signed [15:0] head_now;

    // Shared multiplier operands.
    logic signed [23:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [48:0] mul_p;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        mul_a = '0; mul_b = '0;
        unique case (state_reg)
            ST_MUL: begin
                case (mstep_reg)
                    3'd0: begin mul_a = 24'(qy_reg); mul_b = 25'(qz_reg); end
                    3'd1: begin mul_a = 24'(qw_reg); mul_b = 25'(qx_reg); end
                    3'd2: begin mul_a = 24'(qw_reg); mul_b = 25'(qw_reg); end
                    3'd3: begin mul_a = 24'(qz_reg); mul_b = 25'(qz_reg); end
                    3'd4: begin mul_a = 24'(wz_reg); mul_b = 25'(KYaw); end
                    3'd5: begin mul_a = 24'(corr_reg); mul_b = 25'(KCorr); end
                    3'd6: begin mul_a = 24'(vy_reg) + 24'(vx_reg); mul_b = 25'(KLin); end
                    default: begin mul_a = 24'(vx_reg) - 24'(vy_reg); mul_b = 25'(KLin); end
                endcase
            end
            ST_PID: begin
                case (mstep_reg)
                    3'd0: begin mul_a = 24'(err_reg); mul_b = 25'({1'b0, gain_prop_reg}); end
                    3'd1: begin mul_a = 24'(err_reg) - 24'(last_err_reg);
                                mul_b = 25'({1'b0, gain_diff_reg}); end
                    default: begin mul_a = 24'(err_reg) + 24'(last_err_reg);
                                   mul_b = 25'({1'b0, gain_sum_reg}); end
                endcase
            end
            default: ;
        endcase
    end
    assign mul_p = 49'(mul_a) * 49'(mul_b);

    assign head_now = cordic_head;

    function automatic logic signed [23:0] wsat(input logic signed [47:0] v);
        logic signed [47:0] r;
        begin
            r = (v + 48'sd32768) >>> 16;
            if (r > 48'sd8388607) return 24'sd8388607;
            if (r < -48'sd8388608) return -24'sd8388608;
            return r[23:0];
        end
    endfunction

    always_comb begin
        state_next = state_reg; mstep_next = mstep_reg; cordic_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (s_valid && s_ready) begin
                state_next = ST_MUL; mstep_next = '0;
            end
            ST_MUL: begin
                mstep_next = mstep_reg + 1'b1;
                if (mstep_reg == 3'd7) begin
                    state_next = ST_HEAD; cordic_start = 1'b1;
                end
            end
            ST_HEAD: if (cordic_done) begin
                state_next = ST_PID; mstep_next = '0;
            end
            ST_PID: begin
                mstep_next = mstep_reg + 1'b1;
                if (mstep_reg == 3'd2) state_next = ST_CORR;
            end
            ST_CORR: state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    owhh_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cordic_start),
        .vec_s(s_acc_reg), .vec_c(c_acc_reg),
        .done(cordic_done), .heading(cordic_head)
    );

    logic signed [47:0] corr_sh;
    assign corr_sh = (acc_reg + 48'sd1024) >>> 11;

    // Sequencer datapath: accumulate products, then finish and publish.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mstep_reg     <= '0;
            gain_prop_reg <= 16'd655;
            gain_diff_reg <= 16'd3277;
            gain_sum_reg  <= 16'd0;
            corr_reg      <= '0;
            last_err_reg  <= '0;
            setpoint_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            mstep_reg <= mstep_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    RegGainProp: gain_prop_reg <= cfg_data;
                    RegGainDiff: gain_diff_reg <= cfg_data;
                    RegGainSum:  gain_sum_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_PID && mstep_reg == 3'd0 && wz_reg != 16'sd0)
                setpoint_reg <= head_out_reg;
            if (state_reg == ST_CORR) begin
                corr_reg <= (corr_sh > 48'sd32767) ? 16'sd32767 :
                            (corr_sh < -48'sd32768) ? -16'sd32768 : corr_sh[15:0];
                last_err_reg <= err_reg;
            end
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
        end

        if (s_valid && s_ready) begin
            qx_reg <= s_quat_x; qy_reg <= s_quat_y; qz_reg <= s_quat_z;
            qw_reg <= s_quat_w; vx_reg <= s_cmd_vx; vy_reg <= s_cmd_vy;
            wz_reg <= s_cmd_wz;
        end
        if (state_reg == ST_MUL) begin
            case (mstep_reg)
                3'd0: s_acc_reg <= 34'(mul_p);
                3'd1: s_acc_reg <= (s_acc_reg + 34'(mul_p)) <<< 1;
                3'd2: c_acc_reg <= 34'(mul_p);
                3'd3: c_acc_reg <= ((c_acc_reg + 34'(mul_p)) <<< 1) - 34'(OneQ28);
                3'd4: base_reg  <= 48'(mul_p);
                3'd5: base_reg  <= base_reg - 48'(mul_p);
                3'd6: lsum_reg  <= 48'(mul_p);
                default: ldif_reg <= 48'(mul_p);
            endcase
        end
        if (state_reg == ST_HEAD && cordic_done) begin
            head_out_reg <= head_now;
            err_reg <= (wz_reg != 16'sd0) ? 17'sd0 : 17'(head_now) - 17'(setpoint_reg);
            wfr_reg <= wsat(base_reg - ldif_reg);
            wfl_reg <= wsat(base_reg + lsum_reg);
            wrl_reg <= wsat(base_reg + ldif_reg);
            wrr_reg <= wsat(base_reg - lsum_reg);
        end
        if (state_reg == ST_PID) begin
            case (mstep_reg)
                3'd0: acc_reg <= 48'(mul_p);
                default: acc_reg <= acc_reg + 48'(mul_p);
            endcase
        end
        // Load the output word once the previous one has left.
        if (out_load) begin
            out_fr_reg   <= wfr_reg;
            out_fl_reg   <= wfl_reg;
            out_rl_reg   <= wrl_reg;
            out_rr_reg   <= wrr_reg;
            out_head_reg <= head_out_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_wheel_front_right = out_fr_reg;
    assign m_wheel_front_left  = out_fl_reg;
    assign m_wheel_rear_left   = out_rl_reg;
    assign m_wheel_rear_right  = out_rr_reg;
    assign m_heading_deg       = out_head_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_heading_deg))
        else $error("result dropped");
    a_out_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_ready) |=> state_reg == ST_OUT)
        else $error("output overwritten while pending");
endmodule

[sim/testbench.sv]
// Self-checking testbench for the omni wheel heading hold block.
module testbench;
    import owhh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 2000;

    typedef struct packed {
        logic signed [15:0] qx, qy, qz, qw, vx, vy, wz;
    } tick_t;

    typedef struct packed {
        logic signed [23:0] fr, fl, rl, rr;
        logic signed [15:0] head;
    } drive_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_quat_x = '0, s_quat_y = '0, s_quat_z = '0, s_quat_w = '0;
    logic signed [15:0] s_cmd_vx = '0, s_cmd_vy = '0, s_cmd_wz = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [23:0] m_wheel_front_right, m_wheel_front_left;
    logic signed [23:0] m_wheel_rear_left, m_wheel_rear_right;
    logic signed [15:0] m_heading_deg;

    omni_wheel_heading_hold i_dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Predictor state
    longint gp, gd, gs, corr, last_err, setpoint;
    tick_t  pending_ticks[$];
    drive_t expected_drive[$];
    int     errors = 0;
    int     idle_cycles = 0;
    bit     done = 1'b0;

    function automatic longint floor_sh(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint cordic_heading(longint s, longint c);
        longint x = c, y = s, z = 0, t, dx, dy;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 90 * 65536;
            end else begin
                x = -y; y = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < CordicSteps && i < 24; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(atan_deg(i[4:0]));
            end else begin
                x -= dx; y += dy; z -= longint'(atan_deg(i[4:0]));
            end
        end
        return clampl(floor_sh(z + 256, 9), -23040, 23040);
    endfunction

    function automatic logic signed [23:0] wheel_speed(longint lin, longint yaw, longint cr);
        return 24'(clampl(floor_sh(lin * 390075 + yaw - cr + 32768, 16), -8388608, 8388607));
    endfunction

    // Work out one tick's wheel speeds and heading, then advance the hold loop.
    function automatic drive_t predict_drive(tick_t t);
        drive_t d;
        longint vx = t.vx, vy = t.vy, yaw, cr, s, c, h, e, acc;
        yaw = longint'(t.wz) * 68956;
        cr  = corr * 3309899;
        d.fr = wheel_speed(-vx + vy, yaw, cr);
        d.fl = wheel_speed(vx + vy, yaw, cr);
        d.rl = wheel_speed(vx - vy, yaw, cr);
        d.rr = wheel_speed(-vx - vy, yaw, cr);
        s = 2 * (longint'(t.qy) * t.qz + longint'(t.qw) * t.qx);
        c = 2 * (longint'(t.qw) * t.qw + longint'(t.qz) * t.qz) - 268435456;
        h = cordic_heading(s, c);
        d.head = 16'(h);
        if (t.wz != 0) setpoint = h;
        e = h - setpoint;
        acc = gp * e + gd * (e - last_err) + gs * (e + last_err);
        corr = clampl(floor_sh(acc + 1024, 11), -32768, 32767);
        last_err = e;
        return d;
    endfunction

    function automatic logic signed [15:0] rand_q();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 32768)) - 16'sd16384;
            1: return 16'($urandom);
            2: return 16'($urandom_range(0, 2048)) - 16'sd1024;
            default: return '0;
        endcase
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        t.qx = rand_q(); t.qy = rand_q(); t.qz = rand_q(); t.qw = rand_q();
        t.vx = 16'($urandom); t.vy = 16'($urandom);
        case ($urandom_range(0, 3))
            0: t.wz = '0;
            1: t.wz = 16'($urandom);
            default: t.wz = 16'($urandom_range(0, 512)) - 16'sd256;
        endcase
        if ($urandom_range(0, 3) == 0) begin
            t.vx = 16'($urandom_range(0, 1000)) - 16'sd500;
            t.vy = 16'($urandom_range(0, 1000)) - 16'sd500;
        end
        return t;
    endfunction

    // Driver: hold each word until accepted, with a random gap before each.
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && s_ready) begin
            expected_drive.push_back(predict_drive({s_quat_x, s_quat_y, s_quat_z, s_quat_w,
                                                   s_cmd_vx, s_cmd_vy, s_cmd_wz}));
            s_valid  <= 1'b0;
            send_gap <= $urandom_range(0, 7);
        end else if (!s_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_ticks.size() > 0) begin
                tick_t t;
                t = pending_ticks.pop_front();
                {s_quat_x, s_quat_y, s_quat_z, s_quat_w, s_cmd_vx, s_cmd_vy, s_cmd_wz} <= t;
                s_valid <= 1'b1;
            end
        end
    end

    // Monitor: stall randomly, compare each accepted word with the oldest prediction.
    int recv_gap = 0;
    always @(posedge aclk) begin
        int g;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_drive.size() == 0) begin
                    $error("unexpected result word");
                    errors++;
                end else begin
                    drive_t d;
                    d = expected_drive.pop_front();
                    if (m_wheel_front_right !== d.fr) begin
                        $error("wheel_front_right exp %0d got %0d", d.fr, m_wheel_front_right);
                        errors++;
                    end
                    if (m_wheel_front_left !== d.fl) begin
                        $error("wheel_front_left exp %0d got %0d", d.fl, m_wheel_front_left);
                        errors++;
                    end
                    if (m_wheel_rear_left !== d.rl) begin
                        $error("wheel_rear_left exp %0d got %0d", d.rl, m_wheel_rear_left);
                        errors++;
                    end
                    if (m_wheel_rear_right !== d.rr) begin
                        $error("wheel_rear_right exp %0d got %0d", d.rr, m_wheel_rear_right);
                        errors++;
                    end
                    if (m_heading_deg !== d.head) begin
                        $error("heading_deg exp %0d got %0d", d.head, m_heading_deg);
                        errors++;
                    end
                end
            end
            if (m_valid && m_ready) begin
                g = $urandom_range(0, 7);
                recv_gap <= g;
                m_ready  <= (g == 0);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= (recv_gap == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles with no accepted word.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit && !done) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            RegGainProp: gp = val;
            RegGainDiff: gd = val;
            RegGainSum:  gs = val;
            default: ;
        endcase
    endtask

    // Wait until every word has been sent and every result checked.
    task automatic drain();
        do @(negedge aclk);
        while (pending_ticks.size() > 0 || s_valid || expected_drive.size() > 0);
        repeat (30) @(posedge aclk);
    endtask

    task automatic push(int x, y, z, w, vx, vy, wz);
        tick_t t;
        t = {16'(x), 16'(y), 16'(z), 16'(w), 16'(vx), 16'(vy), 16'(wz)};
        pending_ticks.push_back(t);
    endtask

    initial begin
        gp = 655; gd = 3277; gs = 0;
        corr = 0; last_err = 0; setpoint = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: identity, extremes, zero vector, each quadrant, yaw latch.
        push(0, 0, 0, 16384, 0, 0, 0);
        push(0, 0, 0, 0, 0, 0, 0);
        push(0, 0, 0, 0, 32767, 32767, 32767);
        push(0, 0, 0, 0, -32768, -32768, -32768);
        push(0, 0, 0, 0, 32767, -32768, 0);
        push(16384, 0, 0, 0, 0, 0, 100);
        push(-16384, 0, 0, 0, 0, 0, 0);
        push(0, 0, 16384, 0, 0, 0, 0);
        push(11585, 0, 0, 11585, 4096, 0, 0);
        push(-11585, 0, 0, 11585, 0, 4096, 0);
        push(16384, 16384, 16384, 16384, 0, 0, 1);
        push(-16384, -16384, -16384, -16384, 0, 0, 0);
        push(32767, 32767, -32768, 32767, 0, 0, 0);
        push(-32768, 32767, 32767, -32768, 0, 0, -1);
        push(0, 16384, 0, 0, 0, 0, 0);
        push(0, 100, 100, 0, 0, 0, 0);
        drain();

        // Random phases over several gain settings, extremes included.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_reg(RegGainProp, 16'hffff); write_reg(RegGainDiff, 16'hffff);
                         write_reg(RegGainSum, 16'hffff); end
                1: begin write_reg(RegGainProp, 16'd0); write_reg(RegGainDiff, 16'd0);
                         write_reg(RegGainSum, 16'd0); end
                2: begin write_reg(2'd3, 16'h1234); write_reg(RegGainProp, 16'd655);
                         write_reg(RegGainDiff, 16'd3277); end
                default: begin write_reg(RegGainProp, 16'($urandom));
                         write_reg(RegGainDiff, 16'($urandom));
                         write_reg(RegGainSum, 16'($urandom)); end
            endcase
            for (int n = 0; n < 200; n++) pending_ticks.push_back(rand_tick());
            drain();
        end

        done = 1'b1;
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
